/* sv/qrsc_pkg.sv */
// ----------------------------------------------------------------------------
// Quadrilateral rectangle check package
// Shared widths, register indexes, status codes and the configuration and
// result records of the quadrilateral rectangle and size check.
// ----------------------------------------------------------------------------
package qrsc_pkg;

	localparam int COORD_BITS_DEF = 40;
	localparam int EDGE_BITS_DEF  = 24;
	localparam int NUM_CORNERS    = 4;
	localparam int NUM_DOTS       = 2;
	localparam int TAG_BITS       = 32;
	localparam int SIDE_BITS      = 24;
	localparam int COS_BITS       = 16;
	localparam int BOUND_BITS     = 4;
	localparam int STATUS_BITS    = 2;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 24;
	localparam int OUT_TDATA_BITS = 88;

	localparam logic [CFG_IDX_BITS-1:0] REG_LEN_TOL    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_COS_TOL    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_LENGTH = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_LENGTH = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_WIDTH  = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOUNDS     = 3'd6;

	localparam int EN_MIN_LENGTH = 0;
	localparam int EN_MIN_WIDTH  = 1;
	localparam int EN_MAX_LENGTH = 2;
	localparam int EN_MAX_WIDTH  = 3;

	localparam logic [STATUS_BITS-1:0] STATUS_WRONG_POLY = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_NOT_RECT   = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_RECT       = 2'd2;

	localparam logic [SIDE_BITS-1:0] SIDE_MAX = '1;

	typedef struct packed {
		logic [SIDE_BITS-1:0]  length_tolerance;
		logic [COS_BITS-1:0]   cosine_tolerance;
		logic [SIDE_BITS-1:0]  min_length;
		logic [SIDE_BITS-1:0]  min_width;
		logic [SIDE_BITS-1:0]  max_length;
		logic [SIDE_BITS-1:0]  max_width;
		logic [BOUND_BITS-1:0] bound_enables;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		length_tolerance: 24'd10,
		cosine_tolerance: 16'd655,
		min_length:       24'd0,
		min_width:        24'd0,
		max_length:       SIDE_MAX,
		max_width:        SIDE_MAX,
		bound_enables:    4'd0
	};

	typedef struct packed {
		logic [TAG_BITS-1:0]    result_tag;
		logic [STATUS_BITS-1:0] status;
		logic                   length_too_small;
		logic                   width_too_small;
		logic                   length_too_large;
		logic                   width_too_large;
		logic [SIDE_BITS-1:0]   long_side;
		logic [SIDE_BITS-1:0]   short_side;
	} res_t;

endpackage

/* sv/qrsc_edge.sv */
// ----------------------------------------------------------------------------
// Edge vectors, squares and corner dot products
// Three stages: saturated edge differences, squares and cross products of
// the components, then squared lengths and the two absolute dot products.
// ----------------------------------------------------------------------------
module qrsc_edge #(
	parameter int COORD_BITS = qrsc_pkg::COORD_BITS_DEF,
	parameter int EDGE_BITS  = qrsc_pkg::EDGE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic signed [COORD_BITS-1:0]   corner_x [qrsc_pkg::NUM_CORNERS],
	input  logic signed [COORD_BITS-1:0]   corner_y [qrsc_pkg::NUM_CORNERS],
	input  logic                           in_present,
	input  logic [qrsc_pkg::TAG_BITS-1:0]  in_tag,
	output logic                           out_valid,
	output logic [2*EDGE_BITS-1:0]         len_sq [qrsc_pkg::NUM_CORNERS],
	output logic [2*EDGE_BITS-1:0]         dot [qrsc_pkg::NUM_DOTS],
	output logic                           out_present,
	output logic [qrsc_pkg::TAG_BITS-1:0]  out_tag
);

	localparam int NC = qrsc_pkg::NUM_CORNERS;
	localparam int ND = qrsc_pkg::NUM_DOTS;
	localparam int EW = EDGE_BITS;
	localparam int PW = 2 * EDGE_BITS;
	localparam int DW = (COORD_BITS + 1 > EDGE_BITS) ? COORD_BITS + 1 : EDGE_BITS;
	localparam logic signed [DW-1:0] EMAX = DW'((65'd1 << (EDGE_BITS - 1)) - 65'd1);
	localparam logic signed [DW-1:0] EMIN = ~EMAX;

	function automatic logic [EW-1:0] sat_diff(input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b);
		logic signed [DW-1:0] d;
		logic [EW-1:0] r;
		d = $signed({{(DW-COORD_BITS){a[COORD_BITS-1]}}, a})
			- $signed({{(DW-COORD_BITS){b[COORD_BITS-1]}}, b});
		if (d > EMAX) begin
			r = EMAX[EW-1:0];
		end else if (d < EMIN) begin
			r = EMIN[EW-1:0];
		end else begin
			r = d[EW-1:0];
		end
		return r;
	endfunction

	function automatic logic [EW-1:0] mag(input logic [EW-1:0] v);
		return v[EW-1] ? (~v + 1'b1) : v;
	endfunction

	logic            v_s1, v_s2, v_s3;
	logic [EW-1:0]   ex_s1 [NC];
	logic [EW-1:0]   ey_s1 [NC];
	logic            pres_s1, pres_s2, pres_s3;
	logic [qrsc_pkg::TAG_BITS-1:0] tag_s1, tag_s2, tag_s3;

	logic [PW-1:0]   sqx_s2 [NC];
	logic [PW-1:0]   sqy_s2 [NC];
	logic [PW-1:0]   m1_s2 [ND];
	logic [PW-1:0]   m2_s2 [ND];
	logic            dif_s2 [ND];

	logic [PW-1:0]   sq_s3 [NC];
	logic [PW-1:0]   dot_s3 [ND];

	logic [EW-1:0]   mx [NC];
	logic [EW-1:0]   my [NC];

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			mx[i] = mag(ex_s1[i]);
			my[i] = mag(ey_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NC; i++) begin
				ex_s1[i] <= sat_diff(corner_x[(i + 1) % NC], corner_x[i]);
				ey_s1[i] <= sat_diff(corner_y[(i + 1) % NC], corner_y[i]);
				sqx_s2[i] <= PW'(mx[i]) * PW'(mx[i]);
				sqy_s2[i] <= PW'(my[i]) * PW'(my[i]);
				sq_s3[i] <= sqx_s2[i] + sqy_s2[i];
			end
			for (int c = 0; c < ND; c++) begin
				m1_s2[c] <= PW'(mx[c]) * PW'(mx[c + 1]);
				m2_s2[c] <= PW'(my[c]) * PW'(my[c + 1]);
				dif_s2[c] <= ex_s1[c][EW-1] ^ ex_s1[c + 1][EW-1]
					^ ey_s1[c][EW-1] ^ ey_s1[c + 1][EW-1];
				if (!dif_s2[c]) begin
					dot_s3[c] <= m1_s2[c] + m2_s2[c];
				end else if (m1_s2[c] > m2_s2[c]) begin
					dot_s3[c] <= m1_s2[c] - m2_s2[c];
				end else begin
					dot_s3[c] <= m2_s2[c] - m1_s2[c];
				end
			end
			pres_s1 <= in_present;
			pres_s2 <= pres_s1;
			pres_s3 <= pres_s2;
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	assign out_valid   = v_s3;
	assign len_sq      = sq_s3;
	assign dot         = dot_s3;
	assign out_present = pres_s3;
	assign out_tag     = tag_s3;

endmodule

/* sv/qrsc_sqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined square root
// Four lanes of a restoring digit-by-digit square root, one result bit per
// stage, with a sideband word carried alongside each item.
// ----------------------------------------------------------------------------
module qrsc_sqrt #(
	parameter int EDGE_BITS = qrsc_pkg::EDGE_BITS_DEF,
	parameter int SIDE_W    = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [2*EDGE_BITS-1:0]  operand [qrsc_pkg::NUM_CORNERS],
	input  logic [SIDE_W-1:0]       in_side,
	output logic                    out_valid,
	output logic [EDGE_BITS-1:0]    root [qrsc_pkg::NUM_CORNERS],
	output logic [EDGE_BITS+1:0]    rem [qrsc_pkg::NUM_CORNERS],
	output logic [SIDE_W-1:0]       out_side
);

	localparam int NC = qrsc_pkg::NUM_CORNERS;
	localparam int EW = EDGE_BITS;
	localparam int PW = 2 * EDGE_BITS;
	localparam int RW = EDGE_BITS + 2;
	localparam int TW = RW + 2;

	logic              v_s [EW];
	logic [PW-1:0]     op_s [EW][NC];
	logic [EW-1:0]     rt_s [EW][NC];
	logic [RW-1:0]     rm_s [EW][NC];
	logic [SIDE_W-1:0] sd_s [EW];

	for (genvar k = 0; k < EW; k++) begin : g_step
		logic [PW-1:0]     op_i [NC];
		logic [EW-1:0]     rt_i [NC];
		logic [RW-1:0]     rm_i [NC];
		logic              v_i;
		logic [SIDE_W-1:0] sd_i;
		logic [EW-1:0]     rt_n [NC];
		logic [RW-1:0]     rm_n [NC];

		if (k == 0) begin : g_head
			always_comb begin
				v_i  = in_valid;
				sd_i = in_side;
				for (int j = 0; j < NC; j++) begin
					op_i[j] = operand[j];
					rt_i[j] = '0;
					rm_i[j] = '0;
				end
			end
		end else begin : g_tail
			always_comb begin
				v_i  = v_s[k-1];
				sd_i = sd_s[k-1];
				for (int j = 0; j < NC; j++) begin
					op_i[j] = op_s[k-1][j];
					rt_i[j] = rt_s[k-1][j];
					rm_i[j] = rm_s[k-1][j];
				end
			end
		end

		always_comb begin : step
			logic [TW-1:0] remx;
			logic [TW-1:0] trial;
			for (int j = 0; j < NC; j++) begin
				remx  = {rm_i[j], op_i[j][PW-1 -: 2]};
				trial = TW'({rt_i[j], 2'b01});
				if (remx >= trial) begin
					rm_n[j] = RW'(remx - trial);
					rt_n[j] = {rt_i[j][EW-2:0], 1'b1};
				end else begin
					rm_n[j] = remx[RW-1:0];
					rt_n[j] = {rt_i[j][EW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[k] <= sd_i;
				for (int j = 0; j < NC; j++) begin
					op_s[k][j] <= op_i[j] << 2;
					rt_s[k][j] <= rt_n[j];
					rm_s[k][j] <= rm_n[j];
				end
			end
		end
	end

	assign out_valid = v_s[EW-1];
	assign root      = rt_s[EW-1];
	assign rem       = rm_s[EW-1];
	assign out_side  = sd_s[EW-1];

endmodule

/* sv/qrsc_check.sv */
// ----------------------------------------------------------------------------
// Rectangle decision and size bounds
// Rounds the lengths, tests zero edges, opposite edges and the two corner
// angles, and checks the sides against the enabled bounds, in four stages.
// ----------------------------------------------------------------------------
module qrsc_check #(
	parameter int EDGE_BITS = qrsc_pkg::EDGE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [EDGE_BITS-1:0]          root [qrsc_pkg::NUM_CORNERS],
	input  logic [EDGE_BITS+1:0]          rem [qrsc_pkg::NUM_CORNERS],
	input  logic [2*EDGE_BITS-1:0]        dot [qrsc_pkg::NUM_DOTS],
	input  logic                          in_present,
	input  logic [qrsc_pkg::TAG_BITS-1:0] in_tag,
	input  qrsc_pkg::cfg_t                cfg,
	output logic                          out_valid,
	output qrsc_pkg::res_t                out_res
);

	localparam int NC = qrsc_pkg::NUM_CORNERS;
	localparam int ND = qrsc_pkg::NUM_DOTS;
	localparam int EW = EDGE_BITS;
	localparam int RW = EDGE_BITS + 2;
	localparam int PW = 2 * EDGE_BITS;
	localparam int QW = EDGE_BITS + qrsc_pkg::COS_BITS;
	localparam int AW = PW + qrsc_pkg::COS_BITS;
	localparam int CW = (EDGE_BITS > qrsc_pkg::SIDE_BITS) ? EDGE_BITS : qrsc_pkg::SIDE_BITS;

	function automatic logic is_near(input logic [EW-1:0] a, input logic [EW-1:0] b,
		input logic [qrsc_pkg::SIDE_BITS-1:0] tol);
		logic [EW-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return CW'(d) < CW'(tol);
	endfunction

	function automatic logic [qrsc_pkg::SIDE_BITS-1:0] sat_side(input logic [EW-1:0] v);
		return (CW'(v) > CW'(qrsc_pkg::SIDE_MAX)) ? qrsc_pkg::SIDE_MAX
			: qrsc_pkg::SIDE_BITS'(v);
	endfunction

	logic          v_s1, v_s2, v_s3, v_s4;
	logic          pres_s1, pres_s2, pres_s3;
	logic [qrsc_pkg::TAG_BITS-1:0] tag_s1, tag_s2, tag_s3;
	logic [PW-1:0] dot_s1 [ND];
	logic [PW-1:0] dot_s2 [ND];
	logic [PW-1:0] dot_s3 [ND];
	logic [EW-1:0] len_s1 [NC];
	logic          lenok_s2, lenok_s3;
	logic [PW-1:0] prod_s2 [ND];
	logic [EW-1:0] long_s2, long_s3, short_s2, short_s3;
	logic [QW-1:0] plo_s3 [ND];
	logic [QW-1:0] phi_s3 [ND];
	qrsc_pkg::res_t res_s4;

	logic          lenok;
	logic          ang_ok;
	logic [AW-1:0] rhs [ND];
	logic [AW-1:0] lhs [ND];
	qrsc_pkg::res_t res_n;

	always_comb begin
		lenok = is_near(len_s1[0], len_s1[2], cfg.length_tolerance)
			&& is_near(len_s1[1], len_s1[3], cfg.length_tolerance);
		for (int i = 0; i < NC; i++) begin
			if (CW'(len_s1[i]) < CW'(cfg.length_tolerance)) begin
				lenok = 1'b0;
			end
		end
	end

	always_comb begin
		ang_ok = 1'b1;
		for (int c = 0; c < ND; c++) begin
			rhs[c] = (AW'(phi_s3[c]) << EW) + AW'(plo_s3[c]);
			lhs[c] = AW'(dot_s3[c]) << qrsc_pkg::COS_BITS;
			if (!(lhs[c] < rhs[c])) begin
				ang_ok = 1'b0;
			end
		end
	end

	always_comb begin
		res_n = '0;
		res_n.result_tag = tag_s3;
		if (!pres_s3) begin
			res_n.status = qrsc_pkg::STATUS_WRONG_POLY;
		end else if (!(lenok_s3 && ang_ok)) begin
			res_n.status = qrsc_pkg::STATUS_NOT_RECT;
		end else begin
			res_n.status = qrsc_pkg::STATUS_RECT;
			res_n.length_too_small = cfg.bound_enables[qrsc_pkg::EN_MIN_LENGTH]
				&& (CW'(long_s3) < CW'(cfg.min_length));
			res_n.width_too_small = cfg.bound_enables[qrsc_pkg::EN_MIN_WIDTH]
				&& (CW'(short_s3) < CW'(cfg.min_width));
			res_n.length_too_large = cfg.bound_enables[qrsc_pkg::EN_MAX_LENGTH]
				&& (CW'(long_s3) > CW'(cfg.max_length));
			res_n.width_too_large = cfg.bound_enables[qrsc_pkg::EN_MAX_WIDTH]
				&& (CW'(short_s3) > CW'(cfg.max_width));
			res_n.long_side = sat_side(long_s3);
			res_n.short_side = sat_side(short_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NC; i++) begin
				len_s1[i] <= (rem[i] > RW'(root[i])) ? (root[i] + 1'b1) : root[i];
			end
			for (int c = 0; c < ND; c++) begin
				dot_s1[c] <= dot[c];
				dot_s2[c] <= dot_s1[c];
				dot_s3[c] <= dot_s2[c];
				prod_s2[c] <= PW'(len_s1[c]) * PW'(len_s1[c + 1]);
				plo_s3[c] <= QW'(prod_s2[c][EW-1:0]) * QW'(cfg.cosine_tolerance);
				phi_s3[c] <= QW'(prod_s2[c][PW-1:EW]) * QW'(cfg.cosine_tolerance);
			end
			lenok_s2 <= lenok;
			lenok_s3 <= lenok_s2;
			long_s2  <= (len_s1[0] >= len_s1[1]) ? len_s1[0] : len_s1[1];
			short_s2 <= (len_s1[0] >= len_s1[1]) ? len_s1[1] : len_s1[0];
			long_s3  <= long_s2;
			short_s3 <= short_s2;
			pres_s1 <= in_present;
			pres_s2 <= pres_s1;
			pres_s3 <= pres_s2;
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			res_s4 <= res_n;
		end
	end

	assign out_valid = v_s4;
	assign out_res   = res_s4;

endmodule

/* sv/quad_rectangle_size_check.sv */
// ----------------------------------------------------------------------------
// Quadrilateral rectangle and size check
// Classifies a four-corner polygon as a rectangle and checks its sides.
// ----------------------------------------------------------------------------
// The slave stream carries one polygon per transaction: eight corner
// coordinates and the space tag in tdata, the polygon-present flag in tuser.
// The master stream returns one result per polygon, in order: the tag, the
// bound flags and both sides in tdata, the status in tuser.
// Registers are written through the cfg channel, which is always ready; write
// them only while no polygon is in flight.
// A polygon passes the edge, square root and check pipelines in turn; the
// square root, one bit per stage, is the deepest of them. One polygon is
// accepted every cycle while the output buffer is not full.
// A two-entry output buffer absorbs results while the receiver stalls; the
// pipeline halts only when both entries are full, and s_axis_tready then
// returns as soon as one result is taken. Nothing is lost or repeated.
// Reset empties the pipeline and the output buffer and loads the register
// defaults.
// ----------------------------------------------------------------------------
module quad_rectangle_size_check #(
	parameter int COORD_BITS = qrsc_pkg::COORD_BITS_DEF,
	parameter int EDGE_BITS  = qrsc_pkg::EDGE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
	// corner3_x, corner3_y, space_tag, zero fill
	input  logic [((8*COORD_BITS+qrsc_pkg::TAG_BITS+7)/8)*8-1:0] s_axis_tdata,
	// polygon_present
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// result_tag, length_too_small, width_too_small, length_too_large,
	// width_too_large, long_side, short_side, zero fill
	output logic [qrsc_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
	// status
	output logic [qrsc_pkg::STATUS_BITS-1:0] m_axis_tuser,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [qrsc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [qrsc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int NC  = qrsc_pkg::NUM_CORNERS;
	localparam int ND  = qrsc_pkg::NUM_DOTS;
	localparam int TB  = qrsc_pkg::TAG_BITS;
	localparam int PW  = 2 * EDGE_BITS;
	localparam int SIDE_W = TB + 1 + ND * PW;

	qrsc_pkg::cfg_t cfg_q;

	logic en;
	logic signed [COORD_BITS-1:0] cx [NC];
	logic signed [COORD_BITS-1:0] cy [NC];

	logic          e_valid, e_present;
	logic [PW-1:0] e_sq [NC];
	logic [PW-1:0] e_dot [ND];
	logic [TB-1:0] e_tag;

	logic                 r_valid;
	logic [EDGE_BITS-1:0] r_root [NC];
	logic [EDGE_BITS+1:0] r_rem [NC];
	logic [SIDE_W-1:0]    r_side;
	logic [PW-1:0]        r_dot [ND];

	logic           chk_valid;
	qrsc_pkg::res_t chk_res;

	qrsc_pkg::res_t fifo_q [2];
	logic           wptr_q, rptr_q;
	logic [1:0]     cnt_q;
	logic           push, pop;
	qrsc_pkg::res_t rd;

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			cx[i] = s_axis_tdata[(2*i)*COORD_BITS +: COORD_BITS];
			cy[i] = s_axis_tdata[(2*i+1)*COORD_BITS +: COORD_BITS];
		end
		for (int c = 0; c < ND; c++) begin
			r_dot[c] = r_side[c*PW +: PW];
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= qrsc_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				qrsc_pkg::REG_LEN_TOL: begin
					cfg_q.length_tolerance <= cfg_data;
				end
				qrsc_pkg::REG_COS_TOL: begin
					cfg_q.cosine_tolerance <= cfg_data[qrsc_pkg::COS_BITS-1:0];
				end
				qrsc_pkg::REG_MIN_LENGTH: begin
					cfg_q.min_length <= cfg_data;
				end
				qrsc_pkg::REG_MIN_WIDTH: begin
					cfg_q.min_width <= cfg_data;
				end
				qrsc_pkg::REG_MAX_LENGTH: begin
					cfg_q.max_length <= cfg_data;
				end
				qrsc_pkg::REG_MAX_WIDTH: begin
					cfg_q.max_width <= cfg_data;
				end
				qrsc_pkg::REG_BOUNDS: begin
					cfg_q.bound_enables <= cfg_data[qrsc_pkg::BOUND_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign en = (cnt_q != 2'd2);
	assign s_axis_tready = en;

	qrsc_edge #(
		.COORD_BITS(COORD_BITS),
		.EDGE_BITS (EDGE_BITS)
	) u_edge (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_axis_tvalid),
		.corner_x   (cx),
		.corner_y   (cy),
		.in_present (s_axis_tuser),
		.in_tag     (s_axis_tdata[8*COORD_BITS +: TB]),
		.out_valid  (e_valid),
		.len_sq     (e_sq),
		.dot        (e_dot),
		.out_present(e_present),
		.out_tag    (e_tag)
	);

	qrsc_sqrt #(
		.EDGE_BITS(EDGE_BITS),
		.SIDE_W   (SIDE_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (e_valid),
		.operand  (e_sq),
		.in_side  ({e_tag, e_present, e_dot[1], e_dot[0]}),
		.out_valid(r_valid),
		.root     (r_root),
		.rem      (r_rem),
		.out_side (r_side)
	);

	qrsc_check #(
		.EDGE_BITS(EDGE_BITS)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (r_valid),
		.root      (r_root),
		.rem       (r_rem),
		.dot       (r_dot),
		.in_present(r_side[ND*PW]),
		.in_tag    (r_side[ND*PW+1 +: TB]),
		.cfg       (cfg_q),
		.out_valid (chk_valid),
		.out_res   (chk_res)
	);

	assign push = chk_valid && en;
	assign pop  = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= chk_res;
		end
	end

	assign rd            = fifo_q[rptr_q];
	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tuser  = rd.status;
	assign m_axis_tdata  = qrsc_pkg::OUT_TDATA_BITS'({rd.short_side, rd.long_side,
		rd.width_too_large, rd.length_too_large, rd.width_too_small,
		rd.length_too_small, rd.result_tag});

	a_rect_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && rd.status == qrsc_pkg::STATUS_RECT |-> rd.long_side >= rd.short_side)
		else $error("Rectangle result with long side shorter than short side.");

	a_plain_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && rd.status != qrsc_pkg::STATUS_RECT |->
		rd.long_side == '0 && rd.short_side == '0 && !rd.length_too_small
		&& !rd.width_too_small && !rd.length_too_large && !rd.width_too_large)
		else $error("Non-rectangle result carries sides or bound flags.");

	a_resume: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && m_axis_tready |=> s_axis_tready)
		else $error("Input stayed stalled after a full output buffer was drained.");

endmodule
